// ===== rtl/hhsa_pkg.sv =====
`default_nettype none

package hhsa_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int POP_W       = 32;
   localparam int SEAT_W      = 16;
   localparam int SQ_W        = 2 * POP_W;
   localparam int DEN_W       = 2 * SEAT_W;
   localparam int ENTRY_W     = POP_W + SEAT_W;

   localparam int REQ_DATA_W  = ((IDX_W + POP_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((IDX_W + 2 * SEAT_W + 7) / 8) * 8;

   localparam logic [SEAT_W-1:0] SEAT_MAX      = '1;
   localparam logic [SEAT_W-1:0] INITIAL_SEATS = SEAT_W'(1);

   // request kinds carried in tuser
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SEED,
      ST_MUL,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/huntington_hill_seat_allocator.sv =====
// sequence: a load transaction completes in the cycle it is accepted; an allocate
//   transaction passes PREP and SEED for entry 0, then PREP, MUL and CMP for each
//   further entry in use, then DONE, which waits while a held result blocks the award
// overlap: requests are taken only in IDLE; the shared multiply-compare unit visits entries in turn
// reset: synchronous active-high; clears the seat total, sets entries_in_use to 1,
//   empties the result register; table contents stay undefined until loaded
`default_nettype none

module huntington_hill_seat_allocator
   import hhsa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // entry_index, population, zero pad
   input  wire logic [0:0]            req_tuser,   // mode

   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // winner_index, winner_seats, total_seats, zero pad

   // configuration: entries_in_use
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CNT_W-1:0]      csr_data
);

   // ---------------------------------------------------------------------------
   // declarations
   // ---------------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       cand_ff, cand_in;
   logic [IDX_W-1:0]       last_ff, last_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [POP_W-1:0]       best_pop_ff, best_pop_in;
   logic [SEAT_W-1:0]      best_seat_ff, best_seat_in;
   logic [SQ_W-1:0]        best_sq_ff, best_sq_in;
   logic [DEN_W-1:0]       best_den_ff, best_den_in;
   logic [POP_W-1:0]       cand_pop_ff, cand_pop_in;
   logic [SEAT_W-1:0]      cand_seat_ff, cand_seat_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [SQ_W-1:0]        lhs_lo_ff, lhs_lo_in;
   logic [SQ_W-1:0]        lhs_hi_ff, lhs_hi_in;
   logic [SQ_W-1:0]        rhs_lo_ff, rhs_lo_in;
   logic [SQ_W-1:0]        rhs_hi_ff, rhs_hi_in;
   logic [SEAT_W-1:0]      seat_total_ff, seat_total_in;
   logic [CNT_W-1:0]       entries_ff, entries_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // entry memory: population in the upper bits, seat count in the lower bits
   logic [ENTRY_W-1:0]     entry_mem_ff [MAX_ENTRIES];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [ENTRY_W-1:0]     mem_wdata;

   logic                   req_fire;
   logic [POP_W-1:0]       rd_pop;
   logic [SEAT_W-1:0]      rd_seat;
   logic [SQ_W+POP_W-1:0]  lhs_full;
   logic [SQ_W+POP_W-1:0]  rhs_full;
   logic [CNT_W-1:0]       n_eff;
   logic [SEAT_W-1:0]      seat_new;
   logic [SEAT_W-1:0]      total_new;

   // ---------------------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rd_pop  = rd_data_ff[ENTRY_W-1:SEAT_W];
   assign rd_seat = rd_data_ff[SEAT_W-1:0];

   // 96-bit cross products rebuilt from the two registered partial products
   assign lhs_full = {lhs_hi_ff, {POP_W{1'b0}}} + (SQ_W+POP_W)'(lhs_lo_ff);
   assign rhs_full = {rhs_hi_ff, {POP_W{1'b0}}} + (SQ_W+POP_W)'(rhs_lo_ff);

   // clamp the entry count into 1..MAX_ENTRIES
   always_comb begin
      priority if (entries_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (entries_ff > CNT_W'(MAX_ENTRIES)) begin
         n_eff = CNT_W'(MAX_ENTRIES);
      end else begin
         n_eff = entries_ff;
      end
   end

   assign seat_new  = (best_seat_ff == SEAT_MAX) ? best_seat_ff : best_seat_ff + SEAT_W'(1);
   assign total_new = (seat_total_ff == SEAT_MAX) ? seat_total_ff
                                                  : seat_total_ff + SEAT_W'(1);

   // ---------------------------------------------------------------------------
   // sequencer: next state and datapath
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      last_in       = last_ff;
      best_idx_in   = best_idx_ff;
      best_pop_in   = best_pop_ff;
      best_seat_in  = best_seat_ff;
      best_sq_in    = best_sq_ff;
      best_den_in   = best_den_ff;
      cand_pop_in   = cand_pop_ff;
      cand_seat_in  = cand_seat_ff;
      sq_in         = sq_ff;
      den_in        = den_ff;
      lhs_lo_in     = lhs_lo_ff;
      lhs_hi_in     = lhs_hi_ff;
      rhs_lo_in     = rhs_lo_ff;
      rhs_hi_in     = rhs_hi_ff;
      seat_total_in = seat_total_ff;
      entries_in    = csr_valid ? csr_data : entries_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = cand_ff + IDX_W'(1);
      mem_we        = 1'b0;
      mem_waddr     = best_idx_ff;
      mem_wdata     = {best_pop_ff, seat_new};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == MODE_LOAD) begin
                  // load: overwrite the entry with one initial seat
                  mem_we        = 1'b1;
                  mem_waddr     = req_tdata[IDX_W-1:0];
                  mem_wdata     = {req_tdata[IDX_W+POP_W-1:IDX_W], INITIAL_SEATS};
                  seat_total_in = total_new;
               end else begin
                  // allocate: start the scan at entry 0
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  cand_in  = '0;
                  last_in  = IDX_W'(n_eff - CNT_W'(1));
                  state_in = ST_PREP;
               end
            end
         end

         ST_PREP: begin
            // squared population and seat denominator of the candidate
            cand_pop_in  = rd_pop;
            cand_seat_in = rd_seat;
            sq_in        = SQ_W'(rd_pop) * SQ_W'(rd_pop);
            den_in       = DEN_W'(DEN_W'(rd_seat) * (DEN_W'(rd_seat) + DEN_W'(1)));
            state_in     = (cand_ff == '0) ? ST_SEED : ST_MUL;
         end

         ST_SEED: begin
            // entry 0 is the first leader
            best_idx_in  = cand_ff;
            best_pop_in  = cand_pop_ff;
            best_seat_in = cand_seat_ff;
            best_sq_in   = sq_ff;
            best_den_in  = den_ff;
            if (cand_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               cand_in  = cand_ff + IDX_W'(1);
               state_in = ST_PREP;
            end
         end

         ST_MUL: begin
            // candidate squared times leader denominator, and the other way around
            lhs_lo_in = SQ_W'(sq_ff[POP_W-1:0])      * SQ_W'(best_den_ff);
            lhs_hi_in = SQ_W'(sq_ff[SQ_W-1:POP_W])   * SQ_W'(best_den_ff);
            rhs_lo_in = SQ_W'(best_sq_ff[POP_W-1:0]) * SQ_W'(den_ff);
            rhs_hi_in = SQ_W'(best_sq_ff[SQ_W-1:POP_W]) * SQ_W'(den_ff);
            state_in  = ST_CMP;
         end

         ST_CMP: begin
            // strictly greater replaces the leader, so ties stay with the lower index
            if (lhs_full > rhs_full) begin
               best_idx_in  = cand_ff;
               best_pop_in  = cand_pop_ff;
               best_seat_in = cand_seat_ff;
               best_sq_in   = sq_ff;
               best_den_in  = den_ff;
            end
            if (cand_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               cand_in  = cand_ff + IDX_W'(1);
               state_in = ST_PREP;
            end
         end

         ST_DONE: begin
            // award the seat once the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               mem_we        = 1'b1;
               seat_total_in = total_new;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = RSP_DATA_W'({total_new, seat_new, best_idx_ff});
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seat_total_ff <= '0;
         entries_ff    <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seat_total_ff <= seat_total_in;
         entries_ff    <= entries_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      last_ff      <= last_in;
      best_idx_ff  <= best_idx_in;
      best_pop_ff  <= best_pop_in;
      best_seat_ff <= best_seat_in;
      best_sq_ff   <= best_sq_in;
      best_den_ff  <= best_den_in;
      cand_pop_ff  <= cand_pop_in;
      cand_seat_ff <= cand_seat_in;
      sq_ff        <= sq_in;
      den_ff       <= den_in;
      lhs_lo_ff    <= lhs_lo_in;
      lhs_hi_ff    <= lhs_hi_in;
      rhs_lo_ff    <= rhs_lo_in;
      rhs_hi_ff    <= rhs_hi_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // ---------------------------------------------------------------------------
   // entry memory, one write and one registered read per cycle
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
   // the scan never runs past the last entry in use
   a_cand_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cand_ff <= last_ff))
      else $error("scan candidate beyond last entry");

   // the leader always lies below the candidate being compared
   a_best_behind_cand: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_CMP) |-> (best_idx_ff < cand_ff))
      else $error("leader index ahead of candidate");

   // memory writes happen only for a load or the final award
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE || state_ff == ST_DONE))
      else $error("memory write outside load or award");

   // seat total never decreases
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (seat_total_ff >= $past(seat_total_ff)))
      else $error("seat total decreased");

   // a result is produced only on leaving the award state
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> (state_ff == ST_DONE))
      else $error("result raised outside award state");
`endif

endmodule

`default_nettype wire
